/* rtl/lmgb_pkg.sv */
// Shared types and constants for the LED matrix glyph blitter.
package lmgb_pkg;

    localparam int LMGB_MAX_PANELS = 16;
    localparam int LMGB_ADDR_W     = 8;

    typedef enum logic [1:0] {
        CMD_HDRAW = 2'd0,
        CMD_VDRAW = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } cmd_e_t;

    typedef struct packed {
        logic                   en;
        logic [LMGB_ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic                   en;
        logic [LMGB_ADDR_W-1:0] addr;
        logic [7:0]             data;
    } wr_req_t;

endpackage

/* rtl/lmgb_fbmem.sv */
// Frame buffer memory: one read and one write port, per-entry valid bits, write forwarding.
module lmgb_fbmem #(
    parameter int DEPTH = 8 * lmgb_pkg::LMGB_MAX_PANELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lmgb_pkg::rd_req_t rd,
    input  lmgb_pkg::wr_req_t wr,
    output logic [7:0]        rdata
);
    import lmgb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [7:0]       fb_mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [7:0]       mem_q_reg;
    logic             vld_q_reg;
    logic             fwd_reg;
    logic [7:0]       fwd_data_reg;
    logic             hit;

    assign hit = wr.en && rd.en && (wr.addr == rd.addr);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            fb_mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd.en)
        begin
            mem_q_reg    <= fb_mem[rd.addr[AW-1:0]];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            if (rd.en)
            begin
                vld_q_reg <= vld_reg[rd.addr[AW-1:0]];
                fwd_reg   <= hit;
            end
        end
    end

    // an entry never written reads as zero; a same-edge write wins over the old byte
    assign rdata = fwd_reg ? fwd_data_reg : (vld_q_reg ? mem_q_reg : 8'h00);

endmodule

/* rtl/led_matrix_glyph_blitter.sv */
// Glyph blitter top level: command sequencer, read-modify-write pipeline, result register.
// A horizontal draw works through 16 byte slots and a vertical draw through 8; a read
// passes through ST_RD to ST_FIN, and a write or an empty draw goes straight to ST_FIN.
// The frame buffer's single read port serves one byte read-modify-write per cycle
// while a draw runs, and one item is worked on at a time.
// Reset: panel_bytes becomes 1 and every frame buffer byte reads zero at once
// through per-entry valid bits; no clearing pass.
module led_matrix_glyph_blitter #(
    parameter int MAX_PANELS = lmgb_pkg::LMGB_MAX_PANELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,     // panel_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    // position[7:0], glyph[71:8], glyph_width[75:72], address[82:76],
    // write_data[90:83], zero[95:91]
    input  logic [95:0] s_tdata,
    input  logic [1:0]  s_tuser,      // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata       // next_position[7:0], read_data[15:8]
);
    import lmgb_pkg::*;

    localparam int         FB_DEPTH   = 8 * MAX_PANELS;
    localparam logic [8:0] FB_DEPTH_W = 9'(FB_DEPTH);
    localparam logic [5:0] MAX_W      = 6'(MAX_PANELS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    cmd_e_t      cmd_reg, cmd_next;
    logic [63:0] glyph_reg, glyph_next;
    logic [2:0]  bit_reg, bit_next;
    logic        spill_reg, spill_next;
    logic [1:0]  shift_reg, shift_next;
    logic [7:0]  base_reg, base_next;
    logic [3:0]  step_reg, step_next;
    logic [5:0]  pw_reg, pw_next;
    logic [7:0]  nextp_reg, nextp_next;
    logic [6:0]  addr_reg, addr_next;
    logic        rd_ok_reg, rd_ok_next;
    logic        s2_en_reg, s2_en_next;
    logic [7:0]  s2_addr_reg, s2_addr_next;
    logic [7:0]  s2_val_reg, s2_val_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic [4:0]  panel_bytes_reg;

    // input fields
    cmd_e_t      in_cmd;
    logic [7:0]  in_pos;
    logic [63:0] in_glyph;
    logic [3:0]  in_gw;
    logic [6:0]  in_addr;
    logic [7:0]  in_wd;

    logic        accept;
    logic [5:0]  pw;
    logic [3:0]  cw;
    logic [4:0]  line;
    logic [8:0]  nx;
    logic [8:0]  lim;
    logic        at_edge;
    logic        h_ok;
    logic        v_ok;
    logic        addr_ok;
    logic [3:0]  shift_wide;

    logic [2:0]  row_idx;
    logic [7:0]  grow;
    logic [15:0] hpair;
    logic [3:0]  col;
    logic [7:0]  v_val;
    logic        run_en;
    logic [7:0]  run_addr;
    logic [7:0]  run_val;
    logic        run_last;
    logic        is_h;

    rd_req_t     rd;
    wr_req_t     wr;
    logic [7:0]  fb_rdata;

    assign in_cmd   = cmd_e_t'(s_tuser);
    assign in_pos   = s_tdata[7:0];
    assign in_glyph = s_tdata[71:8];
    assign in_gw    = s_tdata[75:72];
    assign in_addr  = s_tdata[82:76];
    assign in_wd    = s_tdata[90:83];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // effective panel count and clipping for the item at the port
    always_comb
    begin
        if (panel_bytes_reg == 5'd0)
        begin
            pw = 6'd1;
        end
        else if ({1'b0, panel_bytes_reg} > MAX_W)
        begin
            pw = MAX_W;
        end
        else
        begin
            pw = {1'b0, panel_bytes_reg};
        end
        cw         = (in_gw > 4'd8) ? 4'd8 : in_gw;
        line       = in_pos[7:3];
        nx         = {1'b0, in_pos} + {5'd0, cw};
        lim        = {pw, 3'b000};
        at_edge    = (nx >= lim);
        h_ok       = (cw != 4'd0) && ({1'b0, line} < pw);
        v_ok       = (cw != 4'd0) && (in_pos < {2'b00, pw});
        addr_ok    = ({2'b00, in_addr} < FB_DEPTH_W);
        shift_wide = (4'd8 - cw) >> 1;
    end

    // per-slot byte address and OR value
    always_comb
    begin
        is_h    = (cmd_reg == CMD_HDRAW);
        row_idx = step_reg[3:1];
        grow    = glyph_reg[{~row_idx, 3'b000} +: 8];
        hpair   = {grow, 8'h00} >> bit_reg;
        col     = {1'b0, step_reg[2:0]} + {2'b00, shift_reg};
        for (int r = 0; r < 8; r++)
        begin
            v_val[7-r] = glyph_reg[8*(7-r) + int'(col[2:0])] & ~col[3];
        end
        if (is_h)
        begin
            run_en   = !step_reg[0] || spill_reg;
            run_addr = base_reg + {7'd0, step_reg[0]};
            run_val  = step_reg[0] ? hpair[7:0] : hpair[15:8];
            run_last = (step_reg == 4'd15);
        end
        else
        begin
            run_en   = 1'b1;
            run_addr = base_reg;
            run_val  = v_val;
            run_last = (step_reg == 4'd7);
        end
    end

    always_comb
    begin
        rd.en   = ((state_reg == ST_RUN) && run_en) || ((state_reg == ST_RD) && rd_ok_reg);
        rd.addr = (state_reg == ST_RD) ? {1'b0, addr_reg} : run_addr;
        if (s2_en_reg)
        begin
            wr.en   = 1'b1;
            wr.addr = s2_addr_reg;
            wr.data = fb_rdata | s2_val_reg;
        end
        else
        begin
            wr.en   = accept && (in_cmd == CMD_WRITE) && addr_ok;
            wr.addr = {1'b0, in_addr};
            wr.data = in_wd;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        glyph_next     = glyph_reg;
        bit_next       = bit_reg;
        spill_next     = spill_reg;
        shift_next     = shift_reg;
        base_next      = base_reg;
        step_next      = step_reg;
        pw_next        = pw_reg;
        nextp_next     = nextp_reg;
        addr_next      = addr_reg;
        rd_ok_next     = rd_ok_reg;
        s2_en_next     = 1'b0;
        s2_addr_next   = run_addr;
        s2_val_next    = run_val;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = in_cmd;
                    glyph_next = in_glyph;
                    bit_next   = in_pos[2:0];
                    spill_next = ((5'(cw) + 5'(in_pos[2:0])) > 5'd8) && !at_edge;
                    shift_next = shift_wide[1:0];
                    pw_next    = pw;
                    step_next  = 4'd0;
                    addr_next  = in_addr;
                    rd_ok_next = addr_ok;
                    nextp_next = 8'd0;
                    state_next = ST_FIN;
                    case (in_cmd)
                        CMD_HDRAW:
                        begin
                            base_next = {3'b000, line};
                            if (!h_ok)
                            begin
                                nextp_next = in_pos;
                            end
                            else
                            begin
                                nextp_next = at_edge ? lim[7:0] : nx[7:0];
                                state_next = ST_RUN;
                            end
                        end
                        CMD_VDRAW:
                        begin
                            base_next  = in_pos;
                            nextp_next = in_pos + 8'd1;
                            if (v_ok)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        CMD_READ:
                        begin
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // read now, merge and write back next cycle
                s2_en_next = run_en;
                step_next  = step_reg + 4'd1;
                if (!is_h || step_reg[0])
                begin
                    base_next = base_reg + {2'b00, pw_reg};
                end
                if (run_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RD:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {((cmd_reg == CMD_READ) && rd_ok_reg) ? fb_rdata : 8'h00,
                                      nextp_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            s2_en_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            panel_bytes_reg <= 5'd1;
        end
        else
        begin
            state_reg     <= state_next;
            s2_en_reg     <= s2_en_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                panel_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        glyph_reg    <= glyph_next;
        bit_reg      <= bit_next;
        spill_reg    <= spill_next;
        shift_reg    <= shift_next;
        base_reg     <= base_next;
        step_reg     <= step_next;
        pw_reg       <= pw_next;
        nextp_reg    <= nextp_next;
        addr_reg     <= addr_next;
        rd_ok_reg    <= rd_ok_next;
        s2_addr_reg  <= s2_addr_next;
        s2_val_reg   <= s2_val_next;
        out_data_reg <= out_data_next;
    end

    lmgb_fbmem #(
        .DEPTH (FB_DEPTH)
    ) u_fbmem (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rd),
        .wr    (wr),
        .rdata (fb_rdata)
    );

    // a buffer write while idle comes only from an accepted write beat
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && wr.en) |-> (accept && in_cmd == CMD_WRITE))
        else $error("buffer write while idle without a write beat");

    // every buffer access stays inside the frame buffer
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en || rd.en) |-> (({1'b0, wr.addr} < FB_DEPTH_W) || !wr.en)
                             && (({1'b0, rd.addr} < FB_DEPTH_W) || !rd.en))
        else $error("frame buffer access out of range");

    // a vertical draw runs eight slots only
    a_vdraw_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && cmd_reg == CMD_VDRAW) |-> !step_reg[3])
        else $error("vertical draw overran its slots");

    // a finished result waits while the output slot is held
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_valid_reg && !m_tready) |=> (state_reg == ST_FIN))
        else $error("result dropped while output stalled");

endmodule

/* dv/tb_led_matrix_glyph_blitter.sv */
// Self-checking stream testbench for the LED matrix glyph blitter.
module tb_led_matrix_glyph_blitter;
    import lmgb_pkg::*;

    localparam int FRAME_DEPTH = 8 * LMGB_MAX_PANELS;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 170;

    typedef struct {
        cmd_e_t    op;
        bit [7:0]  pos;
        bit [63:0] glyph;
        bit [3:0]  glyph_w;
        bit [6:0]  addr;
        bit [7:0]  wdata;
    } blit_item_t;

    typedef struct {
        bit [7:0] next_pos;
        bit [7:0] rdata;
    } blit_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    blit_item_t   pending_q[$];
    blit_result_t expected_q[$];
    bit [7:0]     frame_model [FRAME_DEPTH];
    bit [4:0]     panel_reg = 5'd1;

    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned err_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;
    int unsigned hold_left = 0;
    bit          s_fire = 1'b0;

    led_matrix_glyph_blitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned panels_in_use(bit [4:0] raw);
        if (raw == 0)
            return 1;
        if (raw > LMGB_MAX_PANELS)
            return LMGB_MAX_PANELS;
        return raw;
    endfunction

    function automatic void or_into_frame(int unsigned idx, bit [7:0] v);
        if (idx < FRAME_DEPTH)
            frame_model[idx] = frame_model[idx] | v;
    endfunction

    // Apply one command to the frame model and return what the block should report.
    function automatic blit_result_t blit_into_frame(blit_item_t it);
        blit_result_t res;
        int unsigned  w, cw, line, sh, nx, base, r, c;
        bit           spill;
        bit [7:0]     row;
        res.next_pos = 8'd0;
        res.rdata = 8'd0;
        cw = (it.glyph_w > 8) ? 8 : it.glyph_w;
        w = panels_in_use(panel_reg);
        case (it.op)
            CMD_HDRAW:
            begin
                line = it.pos >> 3;
                sh = it.pos & 7;
                res.next_pos = it.pos;
                if (cw != 0 && line < w)
                begin
                    spill = (cw + sh) > 8;
                    nx = it.pos + cw;
                    if (nx >= w * 8)
                    begin
                        spill = 1'b0;
                        nx = w * 8;
                    end
                    res.next_pos = nx[7:0];
                    for (r = 0; r < 8; r++)
                    begin
                        row = it.glyph[63 - 8 * r -: 8];
                        base = line + r * w;
                        or_into_frame(base, row >> sh);
                        if (spill)
                            or_into_frame(base + 1, 8'(row << (8 - sh)));
                    end
                end
            end
            CMD_VDRAW:
            begin
                res.next_pos = it.pos + 8'd1;
                if (it.pos < w && cw != 0)
                begin
                    sh = (8 - cw) / 2;
                    for (r = 0; r < 8; r++)
                    begin
                        row = it.glyph[63 - 8 * r -: 8] >> sh;
                        for (c = 0; c < 8; c++)
                            if (row[c])
                                or_into_frame(it.pos + w * c, 8'h80 >> r);
                    end
                end
            end
            CMD_READ:
                res.rdata = frame_model[it.addr];
            CMD_WRITE:
                frame_model[it.addr] = it.wdata;
        endcase
        return res;
    endfunction

    task automatic push_item(cmd_e_t op, bit [7:0] pos, bit [63:0] glyph, bit [3:0] gw,
                             bit [6:0] addr, bit [7:0] wdata);
        blit_item_t it;
        it.op = op;
        it.pos = pos;
        it.glyph = glyph;
        it.glyph_w = gw;
        it.addr = addr;
        it.wdata = wdata;
        pending_q.push_back(it);
        n_queued++;
    endtask

    // One scene: clear some bytes, draw a few glyphs, read bytes back; now and then noise.
    task automatic queue_scene(int unsigned w);
        int unsigned n, k, fb_top;
        bit [63:0]   g;
        fb_top = 8 * w - 1;
        if ($urandom_range(9) == 0)
        begin
            push_item(cmd_e_t'($urandom_range(3)), 8'($urandom), {$urandom, $urandom},
                      4'($urandom), 7'($urandom), 8'($urandom));
            return;
        end
        n = $urandom_range(1, 4);
        repeat (n)
            push_item(CMD_WRITE, 8'($urandom), {$urandom, $urandom}, 4'($urandom),
                      7'($urandom_range(fb_top)),
                      ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            g = {$urandom, $urandom};
            if ($urandom_range(1))
                g &= {$urandom, $urandom};
            k = ($urandom_range(7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            if ($urandom_range(1))
                push_item(CMD_HDRAW, 8'($urandom_range(8 * w + 4)), g, 4'(k),
                          7'($urandom), 8'($urandom));
            else
                push_item(CMD_VDRAW, 8'($urandom_range(w + 1)), g, 4'(k),
                          7'($urandom), 8'($urandom));
        end
        n = $urandom_range(1, 4);
        repeat (n)
            push_item(CMD_READ, 8'($urandom), {$urandom, $urandom}, 4'($urandom),
                      7'($urandom_range(fb_top)), 8'($urandom));
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_panels(bit [4:0] v);
        @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin : feed_input
        blit_item_t it;
        if (rst_n && (!s_tvalid || s_fire))
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {5'd0, it.wdata, it.addr, it.glyph_w, it.glyph, it.pos};
                s_tuser <= it.op;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result-side backpressure: random stalls plus an occasional long hold-off.
    always @(negedge clk)
    begin : pace_output
        if (hold_ack != hold_req)
        begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : observe
        blit_item_t   got;
        blit_result_t want;
        bit           moved;
        moved = 1'b0;
        s_fire = rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                panel_reg = cfg_data;
                moved = 1'b1;
            end
            if (s_fire)
            begin
                got.op = cmd_e_t'(s_tuser);
                got.pos = s_tdata[7:0];
                got.glyph = s_tdata[71:8];
                got.glyph_w = s_tdata[75:72];
                got.addr = s_tdata[82:76];
                got.wdata = s_tdata[90:83];
                expected_q.push_back(blit_into_frame(got));
                n_accepted++;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                if (expected_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result beat: next_position %0d read_data 0x%02h",
                                 m_tdata[7:0], m_tdata[15:8]);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tdata[7:0] !== want.next_pos || m_tdata[15:8] !== want.rdata)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: next_position exp %0d got %0d, %s",
                                     want.next_pos, m_tdata[7:0],
                                     $sformatf("read_data exp 0x%02h got 0x%02h",
                                               want.rdata, m_tdata[15:8]));
                    end
                end
            end
            if (moved)
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("led_matrix_glyph_blitter regression: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        bit [4:0]    cfg_val;
        int unsigned ph, w, target, k;
        bit [63:0]   g;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset contents, byte access, edges of the one-byte panel.
        push_item(CMD_READ, 8'd0, '0, 4'd0, 7'd0, 8'd0);
        push_item(CMD_WRITE, 8'hFF, '1, 4'hF, 7'd127, 8'hA5);
        push_item(CMD_READ, 8'd0, '0, 4'd0, 7'd127, 8'd0);
        push_item(CMD_HDRAW, 8'd0, '1, 4'd8, 7'd0, 8'd0);
        push_item(CMD_READ, 8'd0, '0, 4'd0, 7'd0, 8'd0);
        for (k = 0; k < 8; k++)
            push_item(CMD_WRITE, 8'd0, '0, 4'd0, 7'(k), 8'h00);
        push_item(CMD_HDRAW, 8'd2, 64'hE0A0_E000_8040_2010, 4'd3, 7'd0, 8'd0);
        push_item(CMD_HDRAW, 8'd3, '1, 4'd0, 7'd0, 8'd0);
        push_item(CMD_HDRAW, 8'd0, 64'h8142_2418_1824_4281, 4'd15, 7'd0, 8'd0);
        push_item(CMD_HDRAW, 8'd8, '1, 4'd8, 7'd0, 8'd0);
        push_item(CMD_HDRAW, 8'd255, '1, 4'd8, 7'd0, 8'd0);
        push_item(CMD_HDRAW, 8'd5, 64'hFC00_FC00_FC00_FC00, 4'd6, 7'd0, 8'd0);
        push_item(CMD_VDRAW, 8'd0, 64'hF888_F888_8800_F800, 4'd5, 7'd0, 8'd0);
        push_item(CMD_VDRAW, 8'd1, '1, 4'd8, 7'd0, 8'd0);
        push_item(CMD_VDRAW, 8'd255, '1, 4'd8, 7'd0, 8'd0);
        push_item(CMD_VDRAW, 8'd0, '1, 4'd0, 7'd0, 8'd0);
        push_item(CMD_READ, 8'd0, '0, 4'd0, 7'd0, 8'd0);
        push_item(CMD_READ, 8'd0, '0, 4'd0, 7'd7, 8'd0);
        wait_drained();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            case (ph)
                0: cfg_val = 5'd0;
                1: cfg_val = 5'd31;
                2: cfg_val = 5'd16;
                3: cfg_val = 5'd1;
                4: cfg_val = 5'd3;
                5: cfg_val = 5'd17;
                6: cfg_val = 5'd8;
                default: cfg_val = 5'($urandom);
            endcase
            write_panels(cfg_val);
            w = panels_in_use(cfg_val);
            if (ph == 2)
            begin
                // Spill case on a wide panel, then hold results off while items pile up.
                g = 64'hFF81_8181_8181_81FF;
                push_item(CMD_HDRAW, 8'd13, g, 4'd8, 7'd0, 8'd0);
                push_item(CMD_READ, 8'd0, '0, 4'd0, 7'd1, 8'd0);
                push_item(CMD_READ, 8'd0, '0, 4'd0, 7'd2, 8'd0);
            end
            target = n_queued + PHASE_ITEMS;
            while (n_queued < target)
                queue_scene(w);
            if (ph == 2)
                hold_req++;
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("led_matrix_glyph_blitter regression: pass");
        else
            $display("led_matrix_glyph_blitter regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/lmgb_pkg.sv
rtl/lmgb_fbmem.sv
rtl/led_matrix_glyph_blitter.sv
dv/tb_led_matrix_glyph_blitter.sv
